FILE: design/tcw_pkg.sv
// Shared package of the text console writer.
// Holds command codes, character constants and the controller/datapath
// command and status structs. No dependencies.
package tcw_pkg;

  // Geometry defaults handed to the top level parameters
  localparam int ROWS_DEFAULT = 25;
  localparam int COLS_DEFAULT = 80;

  // Command codes carried in the input item
  localparam logic [2:0] CMD_PUT   = 3'd0;
  localparam logic [2:0] CMD_BSP   = 3'd1;
  localparam logic [2:0] CMD_MARK  = 3'd2;
  localparam logic [2:0] CMD_CLEAR = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  // Character constants
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] BLANK_CODE   = 8'd32;

  // Attribute register
  localparam logic [7:0] ATTR_RESET = 8'd15;
  localparam logic       REG_ATTR   = 1'b0;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch;           // capture the accepted input item
    logic put;             // write a character at the cursor, or act on a newline
    logic backspace;       // step the cursor back and blank that cell
    logic mark;            // copy the cursor into the backspace limit
    logic rd_issue;        // read the addressed cell
    logic sw_init_top;     // sweep pointer to row zero
    logic sw_init_one;     // sweep pointer to row one
    logic sw_init_bottom;  // sweep pointer to the bottom row
    logic sw_step;         // advance the sweep pointer
    logic copy_rd;         // read the cell under the sweep pointer for a move up
    logic blank_wr;        // blank the cell under the sweep pointer
    logic load_out;        // load the result into the output register
  } tcw_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [2:0] command;   // command of the captured item
    logic       need_scroll;
    logic       bs_ok;     // cursor lies past the backspace limit
    logic       sw_last;   // sweep pointer sits on the last cell
    logic       out_free;  // output register can take a result
  } tcw_stat_t;

endpackage

FILE: design/tcw_ctrl.sv
// Controller state machine of the text console writer.
// Sequences each item and the scroll and clear sweeps; uses tcw_pkg.
module tcw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  tcw_pkg::tcw_stat_t  stat_i,
  output tcw_pkg::tcw_cmd_t   cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_COPY  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_BLANK = 3'd4;
  localparam logic [2:0] ST_CLEAR = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0] state_q, state_d;

  // Decode the next state and the datapath commands
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_DONE;
        unique case (stat_i.command)
          tcw_pkg::CMD_PUT: begin
            cmd_o.put = 1'b1;
            if (stat_i.need_scroll) begin
              cmd_o.sw_init_one = 1'b1;
              state_d           = ST_COPY;
            end
          end
          tcw_pkg::CMD_BSP:  cmd_o.backspace = stat_i.bs_ok;
          tcw_pkg::CMD_MARK: cmd_o.mark = 1'b1;
          tcw_pkg::CMD_CLEAR: begin
            cmd_o.sw_init_top = 1'b1;
            state_d           = ST_CLEAR;
          end
          tcw_pkg::CMD_READ: cmd_o.rd_issue = 1'b1;
          default: ;
        endcase
      end
      // Move every row below the top one up by one
      ST_COPY: begin
        cmd_o.copy_rd = 1'b1;
        cmd_o.sw_step = 1'b1;
        if (stat_i.sw_last) begin
          state_d = ST_DRAIN;
        end
      end
      // Let the last pending move land, then point at the bottom row
      ST_DRAIN: begin
        cmd_o.sw_init_bottom = 1'b1;
        state_d              = ST_BLANK;
      end
      ST_BLANK, ST_CLEAR: begin
        cmd_o.blank_wr = 1'b1;
        cmd_o.sw_step  = 1'b1;
        if (stat_i.sw_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: design/tcw_datapath.sv
// Datapath of the text console writer: cell memory, cursor, limit,
// sweep pointer and output register. Uses tcw_pkg.
module tcw_datapath #(
  parameter int ROWS = tcw_pkg::ROWS_DEFAULT,
  parameter int COLS = tcw_pkg::COLS_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tcw_pkg::tcw_cmd_t  cmd_i,
  output tcw_pkg::tcw_stat_t stat_o,
  input  logic [7:0]         attr_i,
  input  logic [2:0]         command_i,
  input  logic [7:0]         char_code_i,
  input  logic [4:0]         read_row_i,
  input  logic [6:0]         read_col_i,
  input  logic               m_ready_i,
  output logic               m_valid_o,
  output logic [4:0]         cursor_row_o,
  output logic [6:0]         cursor_col_o,
  output logic [7:0]         cell_char_o,
  output logic [7:0]         cell_attr_o,
  output logic               scrolled_o
);

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = ROWS << CW;
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);

  // Captured item
  logic [2:0] command_q;
  logic [7:0] char_q;
  logic [4:0] rrow_q;
  logic [6:0] rcol_q;

  // Cursor and backspace limit
  logic [RW-1:0] cur_row_q, cur_row_d, lim_row_q;
  logic [CW-1:0] cur_col_q, cur_col_d, lim_col_q;

  // Sweep pointer and pending move
  logic [RW-1:0] sw_row_q, sw_row_d, pend_row_q;
  logic [CW-1:0] sw_col_q, sw_col_d, pend_col_q;
  logic          pend_q;

  // Memory and read data
  logic [15:0]   mem [DEPTH];
  logic [15:0]   rd_data_q;
  logic          rd_hit_q;
  logic          scrolled_q;

  // Output register
  logic          m_valid_q;
  logic [4:0]    out_row_q;
  logic [6:0]    out_col_q;
  logic [15:0]   out_cell_q;
  logic          out_scr_q;

  logic          is_nl, wrap, need_scroll, bs_ok, rd_in;
  logic [RW-1:0] prev_row;
  logic [CW-1:0] prev_col;
  logic          we, re;
  logic [AW-1:0] wa, ra;
  logic [15:0]   wd, blank;

  assign blank       = {attr_i, tcw_pkg::BLANK_CODE};
  assign is_nl       = (char_q == tcw_pkg::NEWLINE_CODE);
  assign wrap        = is_nl || (cur_col_q == LAST_COL);
  assign need_scroll = wrap && (cur_row_q == LAST_ROW);
  assign bs_ok       = (cur_row_q > lim_row_q) ||
                       ((cur_row_q == lim_row_q) && (cur_col_q > lim_col_q));
  assign rd_in       = (int'(rrow_q) < ROWS) && (int'(rcol_q) < COLS);
  assign prev_row    = (cur_col_q == '0) ? cur_row_q - RW'(1) : cur_row_q;
  assign prev_col    = (cur_col_q == '0) ? LAST_COL : cur_col_q - CW'(1);

  assign stat_o.command     = command_q;
  assign stat_o.need_scroll = need_scroll;
  assign stat_o.bs_ok       = bs_ok;
  assign stat_o.sw_last     = (sw_row_q == LAST_ROW) && (sw_col_q == LAST_COL);
  assign stat_o.out_free    = !m_valid_q || m_ready_i;

  // Next cursor
  always_comb begin
    cur_row_d = cur_row_q;
    cur_col_d = cur_col_q;
    if (cmd_i.put) begin
      if (need_scroll) begin
        cur_row_d = LAST_ROW;
        cur_col_d = '0;
      end else if (wrap) begin
        cur_row_d = cur_row_q + RW'(1);
        cur_col_d = '0;
      end else begin
        cur_col_d = cur_col_q + CW'(1);
      end
    end else if (cmd_i.backspace) begin
      cur_row_d = prev_row;
      cur_col_d = prev_col;
    end
  end

  // Next sweep pointer
  always_comb begin
    sw_row_d = sw_row_q;
    sw_col_d = sw_col_q;
    if (cmd_i.sw_init_top) begin
      sw_row_d = '0;
      sw_col_d = '0;
    end else if (cmd_i.sw_init_one) begin
      sw_row_d = RW'(1);
      sw_col_d = '0;
    end else if (cmd_i.sw_init_bottom) begin
      sw_row_d = LAST_ROW;
      sw_col_d = '0;
    end else if (cmd_i.sw_step) begin
      if (sw_col_q == LAST_COL) begin
        sw_row_d = sw_row_q + RW'(1);
        sw_col_d = '0;
      end else begin
        sw_col_d = sw_col_q + CW'(1);
      end
    end
  end

  // Select the one memory write of this cycle
  always_comb begin
    we = 1'b0;
    wa = {cur_row_q, cur_col_q};
    wd = blank;
    priority if (pend_q) begin
      we = 1'b1;
      wa = {pend_row_q - RW'(1), pend_col_q};
      wd = rd_data_q;
    end else if (cmd_i.blank_wr) begin
      we = 1'b1;
      wa = {sw_row_q, sw_col_q};
    end else if (cmd_i.put && !is_nl) begin
      we = 1'b1;
      wd = {attr_i, char_q};
    end else if (cmd_i.backspace) begin
      we = 1'b1;
      wa = {prev_row, prev_col};
    end
  end

  // Read either the sweep cell or the addressed cell
  assign re = cmd_i.copy_rd || (cmd_i.rd_issue && rd_in);
  assign ra = cmd_i.copy_rd ? {sw_row_q, sw_col_q} : {RW'(rrow_q), CW'(rcol_q)};

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data_q <= mem[ra];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      command_q <= command_i;
      char_q    <= char_code_i;
      rrow_q    <= read_row_i;
      rcol_q    <= read_col_i;
    end
    pend_row_q <= sw_row_q;
    pend_col_q <= sw_col_q;
    sw_row_q   <= sw_row_d;
    sw_col_q   <= sw_col_d;
    if (cmd_i.load_out) begin
      out_row_q  <= 5'(cur_row_q);
      out_col_q  <= 7'(cur_col_q);
      out_cell_q <= rd_hit_q ? rd_data_q : 16'd0;
      out_scr_q  <= scrolled_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q  <= '0;
      cur_col_q  <= '0;
      lim_row_q  <= '0;
      lim_col_q  <= '0;
      pend_q     <= 1'b0;
      rd_hit_q   <= 1'b0;
      scrolled_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      cur_row_q <= cur_row_d;
      cur_col_q <= cur_col_d;
      if (cmd_i.mark) begin
        lim_row_q <= cur_row_q;
        lim_col_q <= cur_col_q;
      end
      pend_q <= cmd_i.copy_rd;
      if (cmd_i.latch) begin
        rd_hit_q   <= 1'b0;
        scrolled_q <= 1'b0;
      end else begin
        if (cmd_i.rd_issue) begin
          rd_hit_q <= rd_in;
        end
        if (cmd_i.put && need_scroll) begin
          scrolled_q <= 1'b1;
        end
      end
      if (cmd_i.load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_valid_o    = m_valid_q;
  assign cursor_row_o = out_row_q;
  assign cursor_col_o = out_col_q;
  assign cell_char_o  = out_cell_q[7:0];
  assign cell_attr_o  = out_cell_q[15:8];
  assign scrolled_o   = out_scr_q;

endmodule

FILE: design/text_console_writer.sv
// The item is captured on acceptance, run in EXEC and its result loaded in DONE; no new item until then.
// Scroll: rows move up and the bottom row is blanked, one cell a cycle through the single write port.
// Clear: every cell is blanked, one cell a cycle. Input waits during both sweeps.
// Reset: async active low; cursor and limit go to zero, attribute to 15.
// Cell memory is not cleared by reset; cells hold garbage until written.
module text_console_writer #(
  parameter int ROWS = tcw_pkg::ROWS_DEFAULT,
  parameter int COLS = tcw_pkg::COLS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] command, [10:3] char_code, [15:11] read_row, [22:16] read_col
  input  logic [23:0] s_axis_tdata,
  // Result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] cursor_row, [11:5] cursor_col, [19:12] cell_char, [27:20] cell_attr,
  // [28] scrolled
  output logic [31:0] m_axis_tdata,
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tcw_pkg::tcw_cmd_t  cmd;
  tcw_pkg::tcw_stat_t stat;
  logic [7:0]         attr_q;
  logic [4:0]         cur_row;
  logic [6:0]         cur_col;
  logic [7:0]         cell_char, cell_attr;
  logic               scrolled;

  // Attribute register
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tcw_pkg::ATTR_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == tcw_pkg::REG_ATTR)) begin
      attr_q <= pwdata[7:0];
    end
  end
  assign prdata = (paddr[2] == tcw_pkg::REG_ATTR) ? {24'd0, attr_q} : 32'd0;

  tcw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  tcw_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .attr_i       (attr_q),
    .command_i    (s_axis_tdata[2:0]),
    .char_code_i  (s_axis_tdata[10:3]),
    .read_row_i   (s_axis_tdata[15:11]),
    .read_col_i   (s_axis_tdata[22:16]),
    .m_ready_i    (m_axis_tready),
    .m_valid_o    (m_axis_tvalid),
    .cursor_row_o (cur_row),
    .cursor_col_o (cur_col),
    .cell_char_o  (cell_char),
    .cell_attr_o  (cell_attr),
    .scrolled_o   (scrolled)
  );

  // Pack the result item
  assign m_axis_tdata = {3'd0, scrolled, cell_attr, cell_char, cur_col, cur_row};

endmodule
